// ===== hw/rtl/d96r_pkg.sv =====
// Shared types and constants for the decimal96 round unit.
// No dependencies; imported by d96r_digit_step and decimal96_round_unit.
package d96r_pkg;

  // Action codes
  localparam logic [1:0] ACT_TRUNC  = 2'd0;
  localparam logic [1:0] ACT_FLOOR  = 2'd1;
  localparam logic [1:0] ACT_ROUND  = 2'd2;
  localparam logic [1:0] ACT_NEGATE = 2'd3;

  // The 96-bit mantissa is divided by ten in 24-bit chunks, top chunk first.
  localparam int MANT_W     = 96;
  localparam int CHUNK_W    = 24;
  localparam int NUM_CHUNKS = MANT_W / CHUNK_W;
  localparam int PART_W     = CHUNK_W + 4;            // remainder:chunk
  localparam int RECIP_SH   = 31;
  localparam int PROD_W     = PART_W + RECIP_SH;

  // ceil(2^31 / 10); exact quotient for any part below 2^30
  localparam logic [RECIP_SH-1:0] DIV10_MUL = 31'd214748365;

  // Round up when the first dropped digit reaches this value
  localparam logic [3:0] ROUND_DIGIT = 4'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] mant_low;
    logic [31:0] mant_high;
    logic [4:0]  dec_scale;
    logic        is_negative;
  } cmd_t;

  typedef struct packed {
    logic [63:0] res_low;
    logic [31:0] res_high;
    logic [4:0]  res_scale;
    logic        res_negative;
  } res_t;

  // One pipeline word
  typedef struct packed {
    logic              valid;
    logic [1:0]        action;
    logic              neg;
    logic [4:0]        scale;   // scale as it came in
    logic [4:0]        eff;     // digits to drop
    logic [MANT_W-1:0] mant;
    logic [3:0]        rem;     // running remainder inside one digit pass
    logic              any;     // some dropped digit nonzero
    logic [3:0]        first;   // most significant dropped digit so far
  } pipe_t;

endpackage

// ===== hw/rtl/decimal96_round_unit.sv =====
// Decimal96 round unit: truncate, floor, round half away, negate.
// Depends on d96r_pkg and d96r_digit_step.
//
// Usage:
//   Drive operand and pulse start; a word is taken at every edge with
//   start high and busy low. busy is always low, so one word may enter
//   every cycle.
//   Each result appears on result for exactly one cycle with done high,
//   in the order the words came in. The receiver cannot hold results off.
// Pipeline: MAX_SCALE divide-by-ten passes, then the output register.
//   Each dropped digit is one divide-by-ten pass of four stages, one
//   24-bit chunk per stage (one 28x31 reciprocal multiply); the last
//   stage applies the floor or round increment.
// Throughput: one word per cycle.
// Reset: clears all valid bits; words in flight are dropped and done
//   stays low until new words come through.
// Scale above MAX_SCALE drops MAX_SCALE digits; negate keeps the scale.
module decimal96_round_unit #(
  parameter int MAX_SCALE = 28
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  d96r_pkg::cmd_t operand,
  output logic           done,
  output d96r_pkg::res_t result
);
  import d96r_pkg::*;

  localparam int NSTG = MAX_SCALE * NUM_CHUNKS;

  pipe_t              link [0:NSTG];
  logic               inc;
  logic [MANT_W-1:0]  sum;

  assign busy = 1'b0;

  // Entry word
  always_comb begin
    link[0].valid  = start;
    link[0].action = operand.action;
    link[0].neg    = operand.is_negative;
    link[0].scale  = operand.dec_scale;
    if (operand.action == ACT_NEGATE) begin
      link[0].eff = 5'd0;
    end else if (operand.dec_scale > 5'(MAX_SCALE)) begin
      link[0].eff = 5'(MAX_SCALE);
    end else begin
      link[0].eff = operand.dec_scale;
    end
    link[0].mant  = {operand.mant_high, operand.mant_low};
    link[0].rem   = 4'd0;
    link[0].any   = 1'b0;
    link[0].first = 4'd0;
  end

  // Divide-by-ten passes
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    d96r_digit_step #(
      .CHUNK(g % NUM_CHUNKS),
      .DIGIT(g / NUM_CHUNKS)
    ) u_step (
      .clk (clk),
      .rst (rst),
      .din (link[g]),
      .dout(link[g+1])
    );
  end

  // Floor / round increment
  always_comb begin
    inc = ((link[NSTG].action == ACT_FLOOR) && link[NSTG].neg && link[NSTG].any) ||
          ((link[NSTG].action == ACT_ROUND) && (link[NSTG].first >= ROUND_DIGIT));
    sum = link[NSTG].mant + MANT_W'(inc);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= link[NSTG].valid;
    end
    result.res_low  <= sum[63:0];
    result.res_high <= sum[95:64];
    if (link[NSTG].action == ACT_NEGATE) begin
      result.res_scale    <= link[NSTG].scale;
      result.res_negative <= ~link[NSTG].neg;
    end else begin
      result.res_scale    <= 5'd0;
      result.res_negative <= link[NSTG].neg;
    end
  end

  // Every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(NSTG + 1) done)
    else $error("accepted word did not complete on time");

  // No result without a word at the pipe end
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !link[NSTG].valid |=> !done)
    else $error("done without a word in flight");

  // With no digits dropped the mantissa passes through unchanged
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (link[NSTG].valid && link[NSTG].eff == 5'd0) |=>
      ({result.res_high, result.res_low} == $past(link[NSTG].mant)))
    else $error("mantissa changed with nothing dropped");

  // Non-negate results have scale zero
  a_scale_zero: assert property (@(posedge clk) disable iff (rst)
    (link[NSTG].valid && link[NSTG].action != ACT_NEGATE) |=> (result.res_scale == 5'd0))
    else $error("integer result with nonzero scale");

endmodule

// ===== hw/rtl/d96r_digit_step.sv =====
// One pipeline stage: one 24-bit chunk of a divide-by-ten pass.
// Depends on d96r_pkg.
module d96r_digit_step #(
  parameter int CHUNK = 0,   // chunk position, 0 is the top chunk
  parameter int DIGIT = 0    // which dropped digit this pass produces
) (
  input  logic           clk,
  input  logic           rst,
  input  d96r_pkg::pipe_t din,
  output d96r_pkg::pipe_t dout
);
  import d96r_pkg::*;

  localparam int LSB = (NUM_CHUNKS - 1 - CHUNK) * CHUNK_W;

  logic              active;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [CHUNK_W-1:0] quot;
  logic [PART_W-1:0] back;
  logic [3:0]        digit;
  pipe_t             nxt;

  // Long division step: remainder from the chunk above plus this chunk
  always_comb begin
    active = (5'(DIGIT) < din.eff);
    part   = {(CHUNK == 0) ? 4'd0 : din.rem, din.mant[LSB +: CHUNK_W]};
    prod   = PROD_W'(part) * PROD_W'(DIV10_MUL);
    quot   = prod[RECIP_SH +: CHUNK_W];
    back   = part - (PART_W'(quot) << 3) - (PART_W'(quot) << 1);
    digit  = back[3:0];
  end

  // Next word
  always_comb begin
    nxt = din;
    if (active) begin
      nxt.mant[LSB +: CHUNK_W] = quot;
      nxt.rem = digit;
      if (CHUNK == NUM_CHUNKS - 1) begin
        nxt.any   = din.any | (digit != 4'd0);
        nxt.first = digit;
      end
    end
  end

  // Stage register; only valid is reset
  always_ff @(posedge clk) begin
    dout <= nxt;
    if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench for decimal96_round_unit: truncate, floor, round and negate on 96-bit decimals.
// Depends on d96r_pkg and the decimal96_round_unit RTL; results checked against a local predictor.
module testbench;
  import d96r_pkg::*;

  localparam int LATENCY = 4 * 28 + 1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t operand;
  logic done;
  res_t result;

  res_t pending_results[$];
  int   error_count;
  int   words_sent;
  int   words_checked;

  decimal96_round_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .done(done),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predict one result word from one command word
  function automatic res_t round_predict(cmd_t c);
    res_t r;
    logic [95:0] m;
    logic [3:0] digit;
    logic [3:0] first_digit;
    logic any_nonzero;
    int drop;
    first_digit = '0;
    any_nonzero = 1'b0;
    if (c.action == ACT_NEGATE) begin
      r.res_low = c.mant_low;
      r.res_high = c.mant_high;
      r.res_scale = c.dec_scale;
      r.res_negative = ~c.is_negative;
      return r;
    end
    m = {c.mant_high, c.mant_low};
    drop = (c.dec_scale > 28) ? 28 : c.dec_scale;
    for (int i = 0; i < drop; i++) begin
      digit = 4'(m % 96'd10);
      m = m / 96'd10;
      if (digit != 0) any_nonzero = 1'b1;
      first_digit = digit;
    end
    if (c.action == ACT_FLOOR && c.is_negative && any_nonzero) m = m + 96'd1;
    if (c.action == ACT_ROUND && first_digit >= 4'd5) m = m + 96'd1;
    r.res_low = m[63:0];
    r.res_high = m[95:64];
    r.res_scale = '0;
    r.res_negative = c.is_negative;
    return r;
  endfunction

  // Result checker: compare each done word with the oldest prediction
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        words_checked++;
        if (result.res_low !== exp_r.res_low) begin
          $display("%0t: res_low exp %h got %h", $time, exp_r.res_low, result.res_low);
          error_count++;
        end
        if (result.res_high !== exp_r.res_high) begin
          $display("%0t: res_high exp %h got %h", $time, exp_r.res_high, result.res_high);
          error_count++;
        end
        if (result.res_scale !== exp_r.res_scale) begin
          $display("%0t: res_scale exp %0d got %0d", $time, exp_r.res_scale,
                   result.res_scale);
          error_count++;
        end
        if (result.res_negative !== exp_r.res_negative) begin
          $display("%0t: res_negative exp %b got %b", $time, exp_r.res_negative,
                   result.res_negative);
          error_count++;
        end
      end
    end
  end

  // Random gap: mostly none or short, sometimes long
  task automatic idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return;
    if (pick < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 60)) @(posedge clk);
  endtask

  // Send one command word; start stays high across back-to-back words
  task automatic send_word(cmd_t c, bit allow_gap);
    start <= 1'b1;
    operand <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(round_predict(c));
    words_sent++;
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      operand <= '0;
      // idle with start low so start drops before the next word
      @(posedge clk);
      idle_gap();
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [95:0] rand_mant();
    logic [95:0] m;
    int kind;
    m = {$urandom, $urandom, $urandom};
    kind = $urandom_range(0, 5);
    case (kind)
      0: m = m >> $urandom_range(0, 95);
      1: m = 96'(64'({$urandom, $urandom}) % 64'd1000000);
      2: m = '1;
      default: ;
    endcase
    return m;
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] a, logic [95:0] m, logic [4:0] s, logic n);
    cmd_t c;
    c.action = a;
    c.mant_low = m[63:0];
    c.mant_high = m[95:64];
    c.dec_scale = s;
    c.is_negative = n;
    return c;
  endfunction

  // Directed: field extremes, every action, halfway digits, oversize scale
  task automatic test_directed();
    for (int a = 0; a < 4; a++) begin
      send_word(make_cmd(2'(a), 96'd0, 5'd0, 1'b1), 1'b0);
      send_word(make_cmd(2'(a), '1, 5'd28, 1'b1), 1'b0);
      send_word(make_cmd(2'(a), 96'd15, 5'd1, 1'b1), 1'b0);
      send_word(make_cmd(2'(a), 96'd1001, 5'd31, 1'b0), 1'b0);
      send_word(make_cmd(2'(a), 96'd149, 5'd2, 1'b1), 1'b0);
    end
    send_word(make_cmd(ACT_ROUND, 96'd14, 5'd1, 1'b0), 1'b0);
    send_word(make_cmd(ACT_FLOOR, 96'd10, 5'd1, 1'b1), 1'b0);
    send_word(make_cmd(ACT_FLOOR, 96'd11, 5'd1, 1'b0), 1'b0);
    send_word(make_cmd(ACT_TRUNC, '1, 5'd0, 1'b0), 1'b0);
    wait_drained();
  endtask

  // Random words with random gaps
  task automatic test_random(int count);
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      c = make_cmd(2'($urandom_range(0, 3)), rand_mant(),
                   ($urandom_range(0, 9) == 0) ? 5'($urandom_range(29, 31))
                                               : 5'($urandom_range(0, 28)),
                   1'($urandom));
      send_word(c, 1'b1);
      if (i == count / 2) wait_drained();
    end
  endtask

  // Back-to-back burst with no gaps
  task automatic test_burst(int count);
    for (int i = 0; i < count; i++)
      send_word(make_cmd(2'($urandom_range(0, 3)), rand_mant(), 5'($urandom_range(0, 31)),
                         1'($urandom)), 1'b0);
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1000);
    test_burst(230);
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d words over all four actions, scales 0..31, both signs;", words_sent);
    $display("checked %0d results including halfway, oversize-scale and gapless runs.",
             words_checked);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
